// File: sv/sobel_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths, register codes, queue entry type and controller states.
// ----------------------------------------------------------------------------
package sobel_pkg;

  // Line store geometry.
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int EW_W      = $clog2(MAX_WIDTH + 1);

  // Field widths.
  localparam int PIX_W   = 8;
  localparam int THR_W   = 11;
  localparam int WID_W   = 11;
  localparam int HGT_W   = 12;
  localparam int ROW_W   = 12;
  localparam int EDGE_W  = 11;

  // Gradient and magnitude arithmetic widths.
  localparam int GRAD_W  = 12;
  localparam int ABS_W   = 10;
  localparam int SQ_W    = 2 * ABS_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int SQRT_MSB = (SUM_W - 1) - ((SUM_W - 1) % 2);

  // Configuration port.
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;
  localparam int IDX_W   = 2;
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT    = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 11'd70;
  localparam logic [WID_W-1:0] WIDTH_RST     = 11'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RST    = 12'd480;
  localparam logic [WID_W-1:0] MIN_WIDTH     = 11'd3;
  localparam logic [HGT_W-1:0] MIN_HEIGHT    = 12'd3;

  // Queue between gradient front and square-root back.
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
  } geom_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_sq;
    logic             row_done;
    logic             frame_done;
  } mag_req_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_READ,
    F_GRAD,
    F_SQUARE,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_HOLD
  } back_state_t;

endpackage
`default_nettype wire

// File: sv/sobel_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel front end
// Accepts pixels, keeps the line stores and the 3x3 window, tracks raster
// position and hands the squared gradient sum of interior pixels to the queue.
// ----------------------------------------------------------------------------
module sobel_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  input  wire [sobel_pkg::PIX_W-1:0]   in_pixel,
  output logic                         in_stall,
  input  sobel_pkg::geom_t             geom,
  input  wire                          restart,
  input  wire                          q_full,
  output logic                         q_push,
  output sobel_pkg::mag_req_t          q_entry
);
  import sobel_pkg::*;

  front_state_t st_r, st_nxt;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] top_rd_r, mid_rd_r;
  logic [PIX_W-1:0] win_r [9];

  logic [COL_W-1:0] col_r, addr_r;
  logic [ROW_W-1:0] row_r;
  logic [PIX_W-1:0] pixel_r;
  logic             interior_r, row_done_r, frame_done_r;

  logic [ABS_W-1:0] ax_r, ay_r;
  logic [SQ_W-1:0]  sqx_r, sqy_r;

  logic accept, wr_en, grad_en, sq_en;

  logic [EW_W-1:0]  eff_w;
  logic [HGT_W-1:0] eff_h;
  logic             last_col, last_row;
  logic signed [GRAD_W-1:0] gx, gy;

  // Effective geometry after clamping.
  always_comb begin
    if (geom.width < MIN_WIDTH) begin
      eff_w = EW_W'(MIN_WIDTH);
    end else if (32'(geom.width) > 32'(MAX_WIDTH)) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = EW_W'(geom.width);
    end
    eff_h = (geom.height < MIN_HEIGHT) ? MIN_HEIGHT : geom.height;
  end

  assign last_col = (EW_W'(col_r) + EW_W'(1)) == eff_w;
  assign last_row = (row_r + ROW_W'(1)) == eff_h;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE:   if (in_valid) st_nxt = F_READ;
      F_READ:   st_nxt = interior_r ? F_GRAD : F_IDLE;
      F_GRAD:   st_nxt = F_SQUARE;
      F_SQUARE: st_nxt = F_PUSH;
      F_PUSH:   if (!q_full) st_nxt = F_IDLE;
      default:  st_nxt = F_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_stall = 1'b1;
    accept   = 1'b0;
    wr_en    = 1'b0;
    grad_en  = 1'b0;
    sq_en    = 1'b0;
    q_push   = 1'b0;
    case (st_r)
      F_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      F_READ:   wr_en   = 1'b1;
      F_GRAD:   grad_en = 1'b1;
      F_SQUARE: sq_en   = 1'b1;
      F_PUSH:   q_push  = !q_full;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Line stores: read at acceptance, written back in the cycle after.
  always_ff @(posedge clk) begin
    if (accept) begin
      top_rd_r <= upper_mem[col_r];
    end
    if (wr_en) begin
      upper_mem[addr_r] <= mid_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid_rd_r <= middle_mem[col_r];
    end
    if (wr_en) begin
      middle_mem[addr_r] <= pixel_r;
    end
  end

  // Raster counters; a geometry write restarts the frame.
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // Beat capture with its position flags.
  always_ff @(posedge clk) begin
    if (accept) begin
      pixel_r      <= in_pixel;
      addr_r       <= col_r;
      interior_r   <= (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
      row_done_r   <= last_col;
      frame_done_r <= last_col && last_row;
    end
  end

  // Window slides left and takes the new right column.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (wr_en) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= top_rd_r;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= mid_rd_r;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= pixel_r;
    end
  end

  // Horizontal and vertical gradients.
  always_comb begin
    gx = (GRAD_W'(win_r[2]) + (GRAD_W'(win_r[5]) << 1) + GRAD_W'(win_r[8]))
       - (GRAD_W'(win_r[0]) + (GRAD_W'(win_r[3]) << 1) + GRAD_W'(win_r[6]));
    gy = (GRAD_W'(win_r[6]) + (GRAD_W'(win_r[7]) << 1) + GRAD_W'(win_r[8]))
       - (GRAD_W'(win_r[0]) + (GRAD_W'(win_r[1]) << 1) + GRAD_W'(win_r[2]));
  end

  // Absolute values, then squares, one register stage each.
  always_ff @(posedge clk) begin
    if (grad_en) begin
      ax_r <= gx[GRAD_W-1] ? ABS_W'(-gx) : ABS_W'(gx);
      ay_r <= gy[GRAD_W-1] ? ABS_W'(-gy) : ABS_W'(gy);
    end
    if (sq_en) begin
      sqx_r <= ax_r * ax_r;
      sqy_r <= ay_r * ay_r;
    end
  end

  assign q_entry.sum_sq     = SUM_W'(sqx_r) + SUM_W'(sqy_r);
  assign q_entry.row_done   = row_done_r;
  assign q_entry.frame_done = frame_done_r;

endmodule
`default_nettype wire

// File: sv/sobel_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel request queue
// Short FIFO of squared gradient sums between the front and the root unit.
// ----------------------------------------------------------------------------
module sobel_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  sobel_pkg::mag_req_t  push_entry,
  output logic                 full,
  input  wire                  pop,
  output sobel_pkg::mag_req_t  pop_entry,
  output logic                 empty
);
  import sobel_pkg::*;

  mag_req_t             slot_r [Q_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]    count_r;

  assign full      = count_r == QCNT_W'(Q_DEPTH);
  assign empty     = count_r == '0;
  assign pop_entry = slot_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/sobel_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel back end
// Iterative square root, one result bit per cycle, then the threshold
// compare and the output register.
// ----------------------------------------------------------------------------
module sobel_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          q_empty,
  input  sobel_pkg::mag_req_t          q_entry,
  output logic                         q_pop,
  input  wire [sobel_pkg::THR_W-1:0]   threshold,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [sobel_pkg::EDGE_W-1:0] out_edge_value,
  output logic                         out_row_done,
  output logic                         out_frame_done
);
  import sobel_pkg::*;

  back_state_t st_r, st_nxt;

  logic [SUM_W-1:0]  rem_r, root_r, bit_r;
  logic [SUM_W-1:0]  rem_nxt, root_nxt, trial;
  logic              row_done_r, frame_done_r;
  logic [EDGE_W-1:0] edge_r;
  logic [EDGE_W-1:0] mag;
  logic              load, step, done;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE:  if (!q_empty) st_nxt = B_RUN;
      B_RUN:   if (bit_r[0]) st_nxt = B_HOLD;
      B_HOLD:  if (!out_stall) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    q_pop     = 1'b0;
    load      = 1'b0;
    step      = 1'b0;
    done      = 1'b0;
    out_valid = 1'b0;
    case (st_r)
      B_IDLE: begin
        q_pop = !q_empty;
        load  = !q_empty;
      end
      B_RUN: begin
        step = 1'b1;
        done = bit_r[0];
      end
      B_HOLD:  out_valid = 1'b1;
      default: out_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // One digit of the root per cycle.
  always_comb begin
    trial = root_r + bit_r;
    if (rem_r >= trial) begin
      rem_nxt  = rem_r - trial;
      root_nxt = (root_r >> 1) + bit_r;
    end else begin
      rem_nxt  = rem_r;
      root_nxt = root_r >> 1;
    end
    mag = root_nxt[EDGE_W-1:0];
  end

  // Root iteration registers.
  always_ff @(posedge clk) begin
    if (load) begin
      rem_r        <= q_entry.sum_sq;
      root_r       <= '0;
      bit_r        <= SUM_W'(1) << SQRT_MSB;
      row_done_r   <= q_entry.row_done;
      frame_done_r <= q_entry.frame_done;
    end else if (step) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      bit_r  <= bit_r >> 2;
    end
  end

  // Thresholded result into the output register.
  always_ff @(posedge clk) begin
    if (done) begin
      edge_r <= (mag > threshold) ? mag : '0;
    end
  end

  assign out_edge_value = edge_r;
  assign out_row_done   = row_done_r;
  assign out_frame_done = frame_done_r;

endmodule
`default_nettype wire

// File: sv/sobel_edge_magnitude_threshold_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel edge magnitude with threshold, top level
// Streaming 3x3 Sobel gradient magnitude over 8-bit pixels in raster order.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one beat per pixel; each interior pixel gives
// one result beat, the floor of sqrt(gx^2 + gy^2) or zero when that is not
// above the threshold, once the pixel below and right of it has arrived.
// The front end takes a border pixel through line store read and window
// update and an interior pixel on through gradient, square and queue push,
// taking no new pixel before it is done with the last. The square root unit
// resolves one root digit a cycle; a result passes load, 11 digits and
// output, held there while out_stall is high. A two-entry queue lets the
// front keep taking pixels while a root is in progress. Writing image_width
// or image_height restarts the frame; configure only while the block is idle.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_threshold_top (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire [sobel_pkg::PIX_W-1:0]     in_pixel,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [sobel_pkg::EDGE_W-1:0]   out_edge_value,
  output logic                           out_row_done,
  output logic                           out_frame_done,
  input  wire                            cfg_psel,
  input  wire                            cfg_penable,
  input  wire                            cfg_pwrite,
  input  wire [sobel_pkg::APB_AW-1:0]    cfg_paddr,
  input  wire [sobel_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic [sobel_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                           cfg_pready
);
  import sobel_pkg::*;

  logic [THR_W-1:0] threshold_r;
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic [IDX_W-1:0] reg_idx;
  logic             cfg_wr, restart;
  geom_t            geom;

  logic     q_push, q_pop, q_full, q_empty;
  mag_req_t push_entry, pop_entry;

  // Register file.
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[APB_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign restart    = cfg_wr && ((reg_idx == REG_WIDTH) || (reg_idx == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_THRESHOLD: threshold_r <= cfg_pwdata[THR_W-1:0];
        REG_WIDTH:     width_r     <= cfg_pwdata[WID_W-1:0];
        REG_HEIGHT:    height_r    <= cfg_pwdata[HGT_W-1:0];
        default:       threshold_r <= threshold_r;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: cfg_prdata = APB_DW'(threshold_r);
      REG_WIDTH:     cfg_prdata = APB_DW'(width_r);
      REG_HEIGHT:    cfg_prdata = APB_DW'(height_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign geom.width  = width_r;
  assign geom.height = height_r;

  sobel_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_pixel (in_pixel),
    .in_stall (in_stall),
    .geom     (geom),
    .restart  (restart),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  sobel_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  sobel_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_entry        (pop_entry),
    .q_pop          (q_pop),
    .threshold      (threshold_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_edge_value (out_edge_value),
    .out_row_done   (out_row_done),
    .out_frame_done (out_frame_done)
  );

  // The queue is never written while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("queue push while full");

  // A frame ends only on the last pixel of a row.
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> out_row_done)
    else $error("frame_done without row_done");

  // A nonzero result always lies above the threshold.
  a_above_thr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_edge_value != '0)) |-> (out_edge_value > threshold_r))
    else $error("edge value not above threshold");

  // An accepted pixel stalls the input in the following cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("back-to-back pixel acceptance");

endmodule
`default_nettype wire
